// File: rtl/qsu_pkg.sv
// ----------------------------------------------------------------------------
// qsu_pkg: shared types and constants for the quoted string unescaper
// Decode modes, result kinds, the queue entry format and the hex helper.
// ----------------------------------------------------------------------------
package qsu_pkg;

  typedef enum logic [1:0] {
    CMD_BODY  = 2'd0,
    CMD_START = 2'd1,
    CMD_END   = 2'd2,
    CMD_RSVD  = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    MODE_IDLE = 3'd0,
    MODE_BODY = 3'd1,
    MODE_ESC  = 3'd2,
    MODE_HEX0 = 3'd3,
    MODE_HEX1 = 3'd4,
    MODE_HEX2 = 3'd5,
    MODE_HEX3 = 3'd6
  } mode_e;

  typedef enum logic [2:0] {
    ERR_NONE      = 3'd0,
    ERR_UNTERM    = 3'd1,
    ERR_ESC_END   = 3'd2,
    ERR_BAD_ESC   = 3'd3,
    ERR_BAD_HEX   = 3'd4
  } err_e;

  localparam logic [7:0] CH_DQUOTE    = 8'h22;
  localparam logic [7:0] CH_APOS      = 8'h27;
  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_SLASH     = 8'h2F;
  localparam logic [7:0] CH_B         = 8'h62;
  localparam logic [7:0] CH_F         = 8'h66;
  localparam logic [7:0] CH_N         = 8'h6E;
  localparam logic [7:0] CH_R         = 8'h72;
  localparam logic [7:0] CH_T         = 8'h74;
  localparam logic [7:0] CH_U         = 8'h75;

  localparam logic [7:0] CTL_BS  = 8'h08;
  localparam logic [7:0] CTL_FF  = 8'h0C;
  localparam logic [7:0] CTL_LF  = 8'h0A;
  localparam logic [7:0] CTL_CR  = 8'h0D;
  localparam logic [7:0] CTL_TAB = 8'h09;

  localparam logic [15:0] UTF8_MAX1 = 16'h007F;
  localparam logic [15:0] UTF8_MAX2 = 16'h07FF;

  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // One queue entry holds every result caused by one input item.
  typedef struct packed {
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
    logic [1:0] last_idx;  // index of the final result in this entry
    logic       closed;
    err_e       err;
  } qsu_entry_t;

  typedef struct packed {
    logic full;
    logic not_empty;
  } qsu_qstat_t;

  // Returns {invalid, value} for one ASCII hex digit.
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [4:0] r;
    r = 5'h10;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b0, 4'(c - 8'h30)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r = {1'b0, 4'(c - 8'h57)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r = {1'b0, 4'(c - 8'h37)};
    end
    return r;
  endfunction

endpackage

// File: rtl/quoted_string_unescape_utf8_core.sv
// Path: each result is registered in the entry queue and then in the output
//   stage before it appears on the master side.
// Throughput: one request per cycle while the queue is not full; results leave
//   one at a time, and a \uXXXX escape yields up to three of them.
// Reset: rst_ni clears the decode state, the queue and the output stage; no
//   string is open afterwards.
// ----------------------------------------------------------------------------
// quoted_string_unescape_utf8_core: quoted string literal decoder
// Decodes a quoted string one text byte per request, resolving backslash
// escapes and \uXXXX escapes into UTF-8, and reports malformed input.
// ----------------------------------------------------------------------------
module quoted_string_unescape_utf8_core import qsu_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  // Request side.
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] data_byte
  input  logic [1:0] s_axis_tuser,   // [1:0] command
  // Result side.
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] out_byte
  output logic [4:0] m_axis_tuser,   // [0] byte_valid, [1] closed, [4:2] error_code
  output logic       m_axis_tlast    // last result caused by one request
);

  qsu_entry_t push_entry, head_entry;
  qsu_qstat_t qstat;
  logic       push, pop, accept;
  logic       byte_valid, closed;
  err_e       err;

  // The front end stalls only when the queue is full; the serialiser drains
  // it independently, so the output side may stall without blocking input
  // until four entries have piled up.
  assign s_axis_tready = !qstat.full;
  assign accept        = s_axis_tvalid && s_axis_tready;

  qsu_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .cmd_i    (cmd_e'(s_axis_tuser)),
    .data_i   (s_axis_tdata),
    .push_o   (push),
    .entry_o  (push_entry)
  );

  qsu_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (push_entry),
    .pop_i   (pop),
    .entry_o (head_entry),
    .stat_o  (qstat)
  );

  qsu_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .entry_i      (head_entry),
    .stat_i       (qstat),
    .pop_o        (pop),
    .ready_i      (m_axis_tready),
    .valid_o      (m_axis_tvalid),
    .byte_o       (m_axis_tdata),
    .byte_valid_o (byte_valid),
    .closed_o     (closed),
    .err_o        (err),
    .last_o       (m_axis_tlast)
  );

  // Close and error results carry a zero byte, which the entry already holds.
  assign m_axis_tuser = {err, closed, byte_valid};

endmodule

// File: rtl/qsu_front.sv
// ----------------------------------------------------------------------------
// qsu_front: input decoder
// Tracks the string state one byte per cycle while requests are accepted and
// builds one queue entry for every input byte that produces results.
// ----------------------------------------------------------------------------
module qsu_front import qsu_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       accept_i,
  input  cmd_e       cmd_i,
  input  logic [7:0] data_i,
  output logic       push_o,
  output qsu_entry_t entry_o
);

  mode_e       mode_q, mode_d;
  logic        dquote_q, dquote_d;
  logic [11:0] acc_q, acc_d;
  logic [4:0]  dig;
  logic [15:0] code;
  logic [7:0]  quote_ch;

  always_comb begin
    mode_d   = mode_q;
    dquote_d = dquote_q;
    acc_d    = acc_q;
    push_o   = 1'b0;
    entry_o  = '{b0: 8'h00, b1: 8'h00, b2: 8'h00, last_idx: 2'd0,
                 closed: 1'b0, err: ERR_NONE};
    dig      = hex_digit(data_i);
    code     = {acc_q, dig[3:0]};
    quote_ch = dquote_q ? CH_DQUOTE : CH_APOS;

    if (cmd_i == CMD_START) begin
      dquote_d = (data_i == CH_DQUOTE);
      mode_d   = MODE_BODY;
      acc_d    = '0;
    end else if (cmd_i == CMD_RSVD || mode_q == MODE_IDLE) begin
      // Nothing happens.
    end else if (cmd_i == CMD_END) begin
      push_o = 1'b1;
      mode_d = MODE_IDLE;
      acc_d  = '0;
      case (mode_q)
        MODE_BODY: entry_o.err = ERR_UNTERM;
        MODE_ESC:  entry_o.err = ERR_ESC_END;
        default:   entry_o.err = ERR_BAD_HEX;
      endcase
    end else begin
      case (mode_q)
        MODE_BODY: begin
          if (data_i == quote_ch) begin
            mode_d         = MODE_IDLE;
            push_o         = 1'b1;
            entry_o.closed = 1'b1;
          end else if (data_i == CH_BACKSLASH) begin
            mode_d = MODE_ESC;
          end else begin
            push_o     = 1'b1;
            entry_o.b0 = data_i;
          end
        end
        MODE_ESC: begin
          mode_d = MODE_BODY;
          push_o = 1'b1;
          case (data_i)
            CH_DQUOTE, CH_APOS, CH_BACKSLASH, CH_SLASH: entry_o.b0 = data_i;
            CH_B: entry_o.b0 = CTL_BS;
            CH_F: entry_o.b0 = CTL_FF;
            CH_N: entry_o.b0 = CTL_LF;
            CH_R: entry_o.b0 = CTL_CR;
            CH_T: entry_o.b0 = CTL_TAB;
            CH_U: begin
              push_o = 1'b0;
              mode_d = MODE_HEX0;
              acc_d  = '0;
            end
            default: begin
              mode_d      = MODE_IDLE;
              acc_d       = '0;
              entry_o.err = ERR_BAD_ESC;
            end
          endcase
        end
        MODE_HEX0, MODE_HEX1, MODE_HEX2: begin
          if (dig[4]) begin
            push_o      = 1'b1;
            mode_d      = MODE_IDLE;
            acc_d       = '0;
            entry_o.err = ERR_BAD_HEX;
          end else begin
            acc_d  = {acc_q[7:0], dig[3:0]};
            mode_d = mode_e'(mode_q + 3'd1);
          end
        end
        MODE_HEX3: begin
          push_o = 1'b1;
          acc_d  = '0;
          if (dig[4]) begin
            mode_d      = MODE_IDLE;
            entry_o.err = ERR_BAD_HEX;
          end else begin
            mode_d = MODE_BODY;
            if (code <= UTF8_MAX1) begin
              entry_o.b0 = code[7:0];
            end else if (code <= UTF8_MAX2) begin
              entry_o.b0       = {3'b110, code[10:6]};
              entry_o.b1       = {2'b10, code[5:0]};
              entry_o.last_idx = 2'd1;
            end else begin
              entry_o.b0       = {4'b1110, code[15:12]};
              entry_o.b1       = {2'b10, code[11:6]};
              entry_o.b2       = {2'b10, code[5:0]};
              entry_o.last_idx = 2'd2;
            end
          end
        end
        default: begin
          mode_d = MODE_IDLE;
          acc_d  = '0;
        end
      endcase
    end

    if (!accept_i) begin
      mode_d   = mode_q;
      dquote_d = dquote_q;
      acc_d    = acc_q;
      push_o   = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MODE_IDLE;
      dquote_q <= 1'b0;
      acc_q    <= '0;
    end else begin
      mode_q   <= mode_d;
      dquote_q <= dquote_d;
      acc_q    <= acc_d;
    end
  end

endmodule

// File: rtl/qsu_queue.sv
// ----------------------------------------------------------------------------
// qsu_queue: short entry queue
// Decouples the decoder from the output serialiser.
// ----------------------------------------------------------------------------
module qsu_queue import qsu_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  qsu_entry_t entry_i,
  input  logic       pop_i,
  output qsu_entry_t entry_o,
  output qsu_qstat_t stat_o
);

  qsu_entry_t          store_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0]   cnt_q;

  assign entry_o          = store_q[rd_ptr_q];
  assign stat_o.full      = (cnt_q == QCNT_W'(QUEUE_DEPTH));
  assign stat_o.not_empty = (cnt_q != '0);

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      store_q[wr_ptr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
      end
      case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + QCNT_W'(1);
        2'b01:   cnt_q <= cnt_q - QCNT_W'(1);
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

// File: rtl/qsu_back.sv
// ----------------------------------------------------------------------------
// qsu_back: output serialiser
// Holds one entry and presents its one to three results in turn.
// ----------------------------------------------------------------------------
module qsu_back import qsu_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  qsu_entry_t entry_i,
  input  qsu_qstat_t stat_i,
  output logic       pop_o,
  input  logic       ready_i,
  output logic       valid_o,
  output logic [7:0] byte_o,
  output logic       byte_valid_o,
  output logic       closed_o,
  output err_e       err_o,
  output logic       last_o
);

  qsu_entry_t cur_q;
  logic       cur_valid_q;
  logic [1:0] idx_q;

  assign valid_o      = cur_valid_q;
  assign last_o       = (idx_q == cur_q.last_idx);
  assign closed_o     = cur_q.closed;
  assign err_o        = cur_q.err;
  assign byte_valid_o = !cur_q.closed && (cur_q.err == ERR_NONE);
  assign pop_o        = stat_i.not_empty && (!cur_valid_q || (ready_i && last_o));

  always_comb begin
    case (idx_q)
      2'd0:    byte_o = cur_q.b0;
      2'd1:    byte_o = cur_q.b1;
      default: byte_o = cur_q.b2;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cur_q <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_valid_q <= 1'b0;
      idx_q       <= '0;
    end else if (pop_o) begin
      cur_valid_q <= 1'b1;
      idx_q       <= '0;
    end else if (cur_valid_q && ready_i) begin
      if (last_o) begin
        cur_valid_q <= 1'b0;
        idx_q       <= '0;
      end else begin
        idx_q <= idx_q + 2'd1;
      end
    end
  end

endmodule

// File: rtl/qsu_checker.sv
// ----------------------------------------------------------------------------
// qsu_checker: port-level checks for the string decoder
// Watches only the top-level ports and is bound to the top level.
// ----------------------------------------------------------------------------
module qsu_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata,
  input logic [4:0] m_axis_tuser,
  input logic       m_axis_tlast
);

  // A decoded byte is never also a close or an error.
  a_kind_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(m_axis_tuser[0] && (m_axis_tuser[1] || m_axis_tuser[4:2] != 3'd0)))
    else $error("decoded byte flagged as close or error");

  // Close and error results end their request and carry a zero byte.
  a_status_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tuser[0]) |-> (m_axis_tlast && m_axis_tdata == 8'h00))
    else $error("status result not final or carries a byte");

  // A close and an error never come together.
  a_close_no_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser[1]) |-> (m_axis_tuser[4:2] == 3'd0))
    else $error("close result carries an error code");

  // A stalled result holds.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
       && $stable(m_axis_tlast)))
    else $error("stalled result changed");

endmodule

bind quoted_string_unescape_utf8_core qsu_checker u_qsu_checker (.*);

// File: sim/quoted_string_unescape_utf8_core_test.sv
// ----------------------------------------------------------------------------
// quoted_string_unescape_utf8_core_test: self-checking bench for the decoder
// Streams quoted string literals into the core one byte per request, predicts
// every decoded byte, close and error result, and checks them in order.
// ----------------------------------------------------------------------------
module quoted_string_unescape_utf8_core_test import qsu_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  // A run of this many cycles without any accepted request or result means
  // the core has locked up. The longest legal quiet stretch is a receiver
  // stall, which at the stall rates used here stays far below this.
  localparam int unsigned QUIET_LIMIT = 3000;
  localparam int unsigned ITEMS_PER_PHASE = 70;

  typedef struct packed {
    cmd_e       cmd;
    logic [7:0] data;
  } text_request_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       closed;
    err_e       err;
    logic       last;
  } decoded_result_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       s_axis_tvalid = 1'b0;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata = '0;   // [7:0] data_byte
  logic [1:0] s_axis_tuser = '0;   // [1:0] command
  logic       m_axis_tvalid;
  logic       m_axis_tready = 1'b0;
  logic [7:0] m_axis_tdata;        // [7:0] out_byte
  logic [4:0] m_axis_tuser;        // [0] byte_valid, [1] closed, [4:2] error_code
  logic       m_axis_tlast;

  quoted_string_unescape_utf8_core i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Requests waiting to be offered, and the results still owed by the core.
  text_request_t   queued_requests[$];
  decoded_result_t expected_results[$];

  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned string_items   = 0;
  int unsigned mismatch_count = 0;
  int unsigned quiet_cycles   = 0;

  // --------------------------------------------------------------------------
  // Decoder prediction. The bench keeps its own copy of the decode state and
  // advances it once per accepted request, in acceptance order.
  // --------------------------------------------------------------------------
  mode_e       dec_mode = MODE_IDLE;
  logic        dq_close = 1'b0;   // set when a double quote closes the string
  logic [11:0] hex_acc  = '0;     // hex digits of a \u escape gathered so far

  // Value of an ASCII hex digit in the low nibble; bit 4 flags a non-digit.
  function automatic logic [4:0] nibble_of(input logic [7:0] c);
    logic [7:0] lc;
    lc = c | 8'h20;
    if (c >= "0" && c <= "9") return {1'b0, c[3:0]};
    if (lc >= "a" && lc <= "f") return {1'b0, c[3:0] + 4'd9};
    return 5'h10;
  endfunction

  task automatic push_result(input logic [7:0] b, input logic valid, input logic closed,
                             input err_e err, input logic last);
    expected_results.push_back('{b, valid, closed, err, last});
  endtask

  // Any error drops the string and reports a single result.
  task automatic abort_string(input err_e err);
    dec_mode = MODE_IDLE;
    hex_acc  = '0;
    push_result(8'h00, 1'b0, 1'b0, err, 1'b1);
  endtask

  task automatic decode_step(input cmd_e cmd, input logic [7:0] c);
    logic [4:0]  digit;
    logic [15:0] code;
    logic [7:0]  closer;
    closer = dq_close ? CH_DQUOTE : CH_APOS;
    if (cmd == CMD_START) begin
      // Only a double quote selects double-quote closing; anything else
      // is treated as an apostrophe. An open string is dropped silently.
      dq_close = (c == CH_DQUOTE);
      dec_mode = MODE_BODY;
      hex_acc  = '0;
    end else if (cmd == CMD_RSVD || dec_mode == MODE_IDLE) begin
      // Reserved commands, and anything outside a string, leave no trace.
    end else if (cmd == CMD_END) begin
      case (dec_mode)
        MODE_BODY: abort_string(ERR_UNTERM);
        MODE_ESC:  abort_string(ERR_ESC_END);
        default:   abort_string(ERR_BAD_HEX);
      endcase
    end else begin
      case (dec_mode)
        MODE_BODY: begin
          if (c == closer) begin
            dec_mode = MODE_IDLE;
            push_result(8'h00, 1'b0, 1'b1, ERR_NONE, 1'b1);
          end else if (c == CH_BACKSLASH) begin
            dec_mode = MODE_ESC;
          end else begin
            push_result(c, 1'b1, 1'b0, ERR_NONE, 1'b1);
          end
        end
        MODE_ESC: begin
          dec_mode = MODE_BODY;
          case (c)
            CH_DQUOTE, CH_APOS, CH_BACKSLASH, CH_SLASH:
                  push_result(c, 1'b1, 1'b0, ERR_NONE, 1'b1);
            CH_B: push_result(CTL_BS, 1'b1, 1'b0, ERR_NONE, 1'b1);
            CH_F: push_result(CTL_FF, 1'b1, 1'b0, ERR_NONE, 1'b1);
            CH_N: push_result(CTL_LF, 1'b1, 1'b0, ERR_NONE, 1'b1);
            CH_R: push_result(CTL_CR, 1'b1, 1'b0, ERR_NONE, 1'b1);
            CH_T: push_result(CTL_TAB, 1'b1, 1'b0, ERR_NONE, 1'b1);
            CH_U: begin
              dec_mode = MODE_HEX0;
              hex_acc  = '0;
            end
            default: abort_string(ERR_BAD_ESC);
          endcase
        end
        default: begin
          // One of the four hex digit modes.
          digit = nibble_of(c);
          if (digit[4]) begin
            abort_string(ERR_BAD_HEX);
          end else if (dec_mode != MODE_HEX3) begin
            hex_acc  = {hex_acc[7:0], digit[3:0]};
            dec_mode = mode_e'(dec_mode + 3'd1);
          end else begin
            code     = {hex_acc, digit[3:0]};
            hex_acc  = '0;
            dec_mode = MODE_BODY;
            // UTF-8 encoding of a single code unit, no surrogate joining.
            if (code <= UTF8_MAX1) begin
              push_result(code[7:0], 1'b1, 1'b0, ERR_NONE, 1'b1);
            end else if (code <= UTF8_MAX2) begin
              push_result({3'b110, code[10:6]}, 1'b1, 1'b0, ERR_NONE, 1'b0);
              push_result({2'b10, code[5:0]}, 1'b1, 1'b0, ERR_NONE, 1'b1);
            end else begin
              push_result({4'b1110, code[15:12]}, 1'b1, 1'b0, ERR_NONE, 1'b0);
              push_result({2'b10, code[11:6]}, 1'b1, 1'b0, ERR_NONE, 1'b0);
              push_result({2'b10, code[5:0]}, 1'b1, 1'b0, ERR_NONE, 1'b1);
            end
          end
        end
      endcase
    end
  endtask

  // --------------------------------------------------------------------------
  // Request driver. A request is held until it is accepted; a new one (or an
  // idle cycle) is chosen only once the previous one has gone through.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin : request_drive
    text_request_t req;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        decode_step(cmd_e'(s_axis_tuser), s_axis_tdata);
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (queued_requests.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          req = queued_requests.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= req.data;
          s_axis_tuser  <= req.cmd;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result monitor. Every accepted result is checked against the oldest
  // prediction, field by field; the ready line stalls at random.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin : result_check
    decoded_result_t want;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_results.size() == 0) begin
          $error("result with nothing expected: out_byte %h, tuser %b, tlast %b",
                 m_axis_tdata, m_axis_tuser, m_axis_tlast);
          mismatch_count++;
        end else begin
          want = expected_results.pop_front();
          if (m_axis_tdata !== want.out_byte) begin
            $error("out_byte: expected %h, actual %h", want.out_byte, m_axis_tdata);
            mismatch_count++;
          end
          if (m_axis_tuser[0] !== want.byte_valid) begin
            $error("byte_valid: expected %b, actual %b", want.byte_valid, m_axis_tuser[0]);
            mismatch_count++;
          end
          if (m_axis_tuser[1] !== want.closed) begin
            $error("closed: expected %b, actual %b", want.closed, m_axis_tuser[1]);
            mismatch_count++;
          end
          if (m_axis_tuser[4:2] !== want.err) begin
            $error("error_code: expected %0d, actual %0d", want.err, m_axis_tuser[4:2]);
            mismatch_count++;
          end
          if (m_axis_tlast !== want.last) begin
            $error("last: expected %b, actual %b", want.last, m_axis_tlast);
            mismatch_count++;
          end
        end
      end
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Lock-up guard: counts cycles in which neither side moves anything.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("quoted_string_unescape_utf8_core_test NOT OK");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus. Requests are queued from the falling edge so that the driver
  // never sees the queue change within its own time step.
  // --------------------------------------------------------------------------
  task automatic add_item(input cmd_e cmd, input logic [7:0] data, input bit counted = 1'b1);
    queued_requests.push_back('{cmd, data});
    if (counted) string_items++;
  endtask

  // Queues every character of a literal as a body request.
  task automatic add_body(input string text);
    for (int i = 0; i < text.len(); i++) add_item(CMD_BODY, text[i]);
  endtask

  // ASCII hex digit for a nibble, letters in random case.
  function automatic logic [7:0] hex_char(input logic [3:0] v);
    if (v < 4'd10) return 8'h30 + v;
    return ($urandom_range(1) ? 8'h61 : 8'h41) + v - 8'd10;
  endfunction

  task automatic add_unicode_escape(input logic [15:0] code);
    add_item(CMD_BODY, CH_BACKSLASH);
    add_item(CMD_BODY, CH_U);
    for (int i = 3; i >= 0; i--) add_item(CMD_BODY, hex_char(code[i*4 +: 4]));
  endtask

  // One string with random content. Most strings close properly; the rest
  // end in each of the ways that the decoder reports as an error.
  task automatic add_random_string();
    logic [7:0]  closer;
    logic [7:0]  b;
    logic [4:0]  nib;
    logic [15:0] code;
    logic [15:0] boundary_codes [6];
    logic [7:0]  simple_escapes [9];
    int unsigned len;
    int unsigned sel;
    int unsigned partial;
    boundary_codes = '{16'h0000, 16'h007F, 16'h0080, 16'h07FF, 16'h0800, 16'hFFFF};
    simple_escapes = '{CH_DQUOTE, CH_APOS, CH_BACKSLASH, CH_SLASH,
                       CH_B, CH_F, CH_N, CH_R, CH_T};

    // Noise between strings: requests that a closed decoder ignores.
    if ($urandom_range(3) == 0) begin
      case ($urandom_range(2))
        0: add_item(CMD_BODY, 8'($urandom_range(255)), 1'b0);
        1: add_item(CMD_END, 8'($urandom_range(255)), 1'b0);
        default: add_item(CMD_RSVD, 8'($urandom_range(255)), 1'b0);
      endcase
    end

    sel = $urandom_range(9);
    b = (sel < 5) ? CH_DQUOTE : (sel < 9) ? CH_APOS : 8'($urandom_range(255));
    add_item(CMD_START, b);
    closer = (b == CH_DQUOTE) ? CH_DQUOTE : CH_APOS;

    len = $urandom_range(10);
    for (int k = 0; k < len; k++) begin
      sel = $urandom_range(99);
      if (sel < 45) begin
        b = 8'($urandom_range(255));
        if (b == closer || b == CH_BACKSLASH) b = b ^ 8'h01;
        add_item(CMD_BODY, b);
      end else if (sel < 70) begin
        add_item(CMD_BODY, CH_BACKSLASH);
        add_item(CMD_BODY, simple_escapes[$urandom_range(8)]);
      end else if (sel < 94) begin
        case ($urandom_range(3))
          0: code = 16'($urandom_range(16'h007F));
          1: code = 16'($urandom_range(16'h07FF, 16'h0080));
          2: code = 16'($urandom_range(16'hFFFF, 16'h0800));
          default: code = boundary_codes[$urandom_range(5)];
        endcase
        add_unicode_escape(code);
      end else if (sel < 97) begin
        add_item(CMD_RSVD, 8'($urandom_range(255)), 1'b0);
      end else begin
        // Restart in the middle of a string.
        b = $urandom_range(1) ? CH_DQUOTE : CH_APOS;
        add_item(CMD_START, b);
        closer = b;
      end
    end

    sel = $urandom_range(99);
    if (sel < 78) begin
      add_item(CMD_BODY, closer);
    end else if (sel < 85) begin
      add_item(CMD_END, 8'($urandom_range(255)));
    end else if (sel < 89) begin
      add_item(CMD_BODY, CH_BACKSLASH);
      add_item(CMD_END, 8'($urandom_range(255)));
    end else if (sel < 94) begin
      b = 8'($urandom_range(255));
      case (b)
        CH_DQUOTE, CH_APOS, CH_BACKSLASH, CH_SLASH,
        CH_B, CH_F, CH_N, CH_R, CH_T, CH_U: b = 8'h78;
        default: ;
      endcase
      add_item(CMD_BODY, CH_BACKSLASH);
      add_item(CMD_BODY, b);
    end else begin
      // Short or broken \u escape: a non-hex byte or the end of text.
      add_item(CMD_BODY, CH_BACKSLASH);
      add_item(CMD_BODY, CH_U);
      partial = $urandom_range(3);
      for (int i = 0; i < partial; i++) add_item(CMD_BODY, hex_char(4'($urandom_range(15))));
      if ($urandom_range(1)) begin
        add_item(CMD_END, 8'($urandom_range(255)));
      end else begin
        b = 8'($urandom_range(255));
        nib = nibble_of(b);
        if (!nib[4]) b = 8'h67;
        add_item(CMD_BODY, b);
      end
    end
  endtask

  task automatic wait_requests_sent();
    while (queued_requests.size() != 0 || s_axis_tvalid) @(negedge clk_i);
  endtask

  task automatic wait_results_drained();
    while (expected_results.size() != 0) @(negedge clk_i);
  endtask

  initial begin
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed opening, with both sides always ready. Requests before any
    // start, and reserved commands, must produce nothing.
    add_item(CMD_RSVD, 8'hFF);
    add_item(CMD_END, 8'h00);
    add_item(CMD_BODY, 8'h41);
    add_item(CMD_START, CH_DQUOTE);
    add_item(CMD_BODY, 8'h00);
    add_item(CMD_BODY, 8'hFF);
    // An apostrophe inside a double-quoted string is plain text, then a
    // newline escape, then a \u escape of code zero with a reserved command
    // slipped between its digits, then the largest code unit.
    add_body("'\\n\\u00");
    add_item(CMD_RSVD, 8'h5A);
    add_body("00\\ufFfF");
    // Restart while open, with a non-quote byte: the apostrophe now closes.
    add_item(CMD_START, 8'h41);
    add_body("\"'");
    // End of text in the body, an unknown escape, a backslash at the end,
    // and a quote byte where a hex digit is due.
    add_item(CMD_START, CH_DQUOTE);
    add_item(CMD_END, 8'h00);
    add_item(CMD_START, CH_APOS);
    add_body("\\x");
    add_item(CMD_START, CH_DQUOTE);
    add_body("\\");
    add_item(CMD_END, 8'hFF);
    add_item(CMD_START, CH_DQUOTE);
    add_body("\\u1\"");
    wait_requests_sent();

    // Hold the sender back until the core has delivered everything.
    wait_results_drained();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 74; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 74; end
        default: begin send_idle_pct = 9; recv_stall_pct = 9; end
      endcase
      string_items = 0;
      while (string_items < ITEMS_PER_PHASE) add_random_string();
      wait_requests_sent();
    end

    // The lock-up guard bounds this wait should results go missing.
    wait_results_drained();
    repeat (8) @(negedge clk_i);

    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("quoted_string_unescape_utf8_core_test OK");
    end else begin
      $display("quoted_string_unescape_utf8_core_test NOT OK");
    end
    $finish;
  end

endmodule
